>>> src/selective_repeat_send_window_unit_macros.svh
// assertion macros for the send window unit
`ifndef SELECTIVE_REPEAT_SEND_WINDOW_UNIT_MACROS_SVH
`define SELECTIVE_REPEAT_SEND_WINDOW_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent holds in a cycle, consequent must hold in that same cycle
`define SRSW_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds in a cycle, consequent must hold in the next cycle
`define SRSW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SRSW_ASSERT_SAME(label, ante, cons, msg)
`define SRSW_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> src/srsw_pkg.sv
package srsw_pkg;

   localparam int SEQ_W          = 15;
   localparam int TIMEOUT_W      = 20;
   localparam int SEQ_SPACE      = 25601;
   localparam int WINDOW_DEFAULT = 10;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd500000;

   typedef logic [SEQ_W-1:0]     seq_type;
   typedef logic [TIMEOUT_W-1:0] timeout_type;

   typedef enum logic [1:0] {
      CMD_SEND = 2'd0,
      CMD_ACK  = 2'd1,
      CMD_TICK = 2'd2
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_BASE_SEQ = 1'b0,
      CSR_TIMEOUT  = 1'b1
   } csr_reg_type;

   typedef enum logic [2:0] {
      EV_SENT     = 3'd0,
      EV_RESENT   = 3'd1,
      EV_ACKED    = 3'd2,
      EV_IGNORED  = 3'd3,
      EV_REFUSED  = 3'd4
   } event_kind_type;

   typedef enum logic {
      OP_ADD,
      OP_SUB_ONE
   } unit_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEND,
      ST_ACK_RED,
      ST_ACK_OFF,
      ST_RUN,
      ST_SHIFT,
      ST_SLIDE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      event_kind_type kind;
      seq_type        seq;
      logic [3:0]     slot;
   } result_type;

endpackage

>>> src/srsw_mod_unit.sv
module srsw_mod_unit
   import srsw_pkg::*;
(
   input  unit_op_type op,
   input  seq_type     a,
   input  seq_type     b,
   output seq_type     result
);

   localparam logic [SEQ_W:0] SPACE_EXT = (SEQ_W+1)'(SEQ_SPACE);

   logic [SEQ_W:0] sum;
   logic [SEQ_W:0] diff;

   // a + b with one correction, a - b - 1 with one wrap
   assign sum  = {1'b0, a} + {1'b0, b};
   assign diff = {1'b0, a} - {1'b0, b} - (SEQ_W+1)'(1);

   always_comb begin
      case (op)
         OP_ADD: begin
            if (sum >= SPACE_EXT) begin
               result = seq_type'(sum - SPACE_EXT);
            end else begin
               result = seq_type'(sum);
            end
         end
         OP_SUB_ONE: begin
            if (diff[SEQ_W]) begin
               result = seq_type'(diff + SPACE_EXT);
            end else begin
               result = seq_type'(diff);
            end
         end
         default: begin
            result = seq_type'(sum);
         end
      endcase
   end

endmodule

>>> src/selective_repeat_send_window_unit.sv
// Selective-repeat sender window.
// Request channel (req_valid/req_ready): command, ack_number, final_packet.
// Response channel (rsp_valid/rsp_ready): one or more events per request,
// rsp_last_of_run marks the final one. A tick with nothing expired and
// command 3 give no response.
// Configuration: csr_write_enable with csr_index 0 loads base_seq and
// restarts the connection; index 1 loads timeout_ticks. Write while idle.
// A request is taken only in the idle state. A send passes the send and emit
// states, an ack the reduce, offset and emit states; an ack that slides also
// runs the run search, then moves one slot per cycle, then slides the window
// start before emit. A tick checks one slot timer per cycle, but waits while
// a resend is held for a stalled receiver. The slot walk goes through the
// single modular adder and the countdown store.
// Reset empties the window, sets window start to 1 and timeout to 500000.
// When the receiver stalls, the output register holds its event; a tick
// scan keeps one more event staged and waits before staging a third.
`include "selective_repeat_send_window_unit_macros.svh"

module selective_repeat_send_window_unit
   import srsw_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_command,
   input  logic [14:0]       req_ack_number,
   input  logic              req_final_packet,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_event_kind,
   output logic [14:0]       rsp_seq_number,
   output logic [3:0]        rsp_slot_index,
   output logic [3:0]        rsp_in_flight,
   output logic              rsp_transfer_done,
   output logic              rsp_last_of_run,
   input  logic              csr_write_enable,
   input  logic [0:0]        csr_index,
   input  logic [19:0]       csr_write_data
);

   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [CNT_W-1:0] WINDOW_CNT = CNT_W'(WINDOW);

   state_type            state_ff, state_in;
   seq_type              ws_ff, ws_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 fin_ff, fin_in;
   logic [WINDOW-1:0]    acked_ff, acked_in;
   timeout_type          to_ff, to_in;
   timeout_type          cd_ff [WINDOW];
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     run_ff, run_in;
   seq_type              ack_ff, ack_in;
   logic                 fpk_ff, fpk_in;
   result_type           stage_ff, stage_in;
   logic                 pend_ff, pend_in;
   result_type           out_ff, out_in;
   logic                 out_last_ff, out_last_in;
   logic [3:0]           out_flight_ff, out_flight_in;
   logic                 out_done_ff, out_done_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 accept;
   logic                 out_free;
   logic                 out_load;
   logic                 out_last;
   logic                 base_write;
   unit_op_type          u_op;
   seq_type              u_a;
   seq_type              u_b;
   seq_type              u_res;
   logic [CNT_W:0]       rd_idx;
   logic [SLOT_W-1:0]    rd_slot;
   timeout_type          cd_rd;
   timeout_type          cd_dec;
   timeout_type          eff_to;
   logic                 cd_we;
   logic [SLOT_W-1:0]    cd_waddr;
   timeout_type          cd_wdata;
   logic                 scan_live;
   logic                 slot_open;
   logic                 expire;
   logic                 off_inside;

   assign accept     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign base_write = csr_write_enable && (csr_index == CSR_BASE_SEQ);
   assign eff_to     = (to_ff == '0) ? timeout_type'(1) : to_ff;

   srsw_mod_unit u_mod (
      .op     (u_op),
      .a      (u_a),
      .b      (u_b),
      .result (u_res)
   );

   // shared adder operand selection
   always_comb begin
      u_op = OP_ADD;
      u_a  = ws_ff;
      u_b  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (base_write) begin
               u_a = csr_write_data[SEQ_W-1:0];
               u_b = seq_type'(1);
            end
         end
         ST_SEND: begin
            u_b = seq_type'(cnt_ff);
         end
         ST_ACK_RED: begin
            u_a = ack_ff;
         end
         ST_ACK_OFF: begin
            u_op = OP_SUB_ONE;
            u_a  = ack_ff;
            u_b  = ws_ff;
         end
         ST_SLIDE: begin
            u_b = seq_type'(run_ff);
         end
         ST_SCAN: begin
            u_b = seq_type'(idx_ff);
         end
         default: begin
            u_b = '0;
         end
      endcase
   end

   assign rd_idx  = (state_ff == ST_SHIFT) ? ({1'b0, idx_ff} + {1'b0, run_ff})
                                           : {1'b0, idx_ff};
   assign rd_slot = rd_idx[SLOT_W-1:0];
   assign cd_rd   = cd_ff[rd_slot];
   assign cd_dec  = (cd_rd == '0) ? '0 : cd_rd - timeout_type'(1);

   assign scan_live  = idx_ff < cnt_ff;
   assign slot_open  = !acked_ff[rd_slot];
   assign expire     = scan_live && slot_open && (cd_dec == '0);
   assign off_inside = u_res < seq_type'(cnt_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_SEND: state_in = ST_SEND;
                  CMD_ACK:  state_in = ST_ACK_RED;
                  CMD_TICK: state_in = ST_SCAN;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEND:    state_in = ST_EMIT;
         ST_ACK_RED: state_in = ST_ACK_OFF;
         ST_ACK_OFF: begin
            if (off_inside && (u_res == '0)) begin
               state_in = ST_RUN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_RUN: begin
            if (!(scan_live && acked_ff[rd_slot])) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (idx_ff + CNT_W'(1) >= cnt_ff) begin
               state_in = ST_SLIDE;
            end
         end
         ST_SLIDE: state_in = ST_EMIT;
         ST_SCAN: begin
            if (!scan_live && (!pend_ff || out_free)) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      ws_in    = ws_ff;
      cnt_in   = cnt_ff;
      fin_in   = fin_ff;
      acked_in = acked_ff;
      to_in    = to_ff;
      idx_in   = idx_ff;
      run_in   = run_ff;
      ack_in   = ack_ff;
      fpk_in   = fpk_ff;
      stage_in = stage_ff;
      pend_in  = pend_ff;
      cd_we    = 1'b0;
      cd_waddr = idx_ff[SLOT_W-1:0];
      cd_wdata = eff_to;
      out_load = 1'b0;
      out_last = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (csr_write_enable) begin
               if (csr_index == CSR_BASE_SEQ) begin
                  ws_in    = u_res;
                  cnt_in   = '0;
                  fin_in   = 1'b0;
                  acked_in = '0;
               end else begin
                  to_in = csr_write_data[TIMEOUT_W-1:0];
               end
            end
            if (accept) begin
               ack_in  = req_ack_number;
               fpk_in  = req_final_packet;
               idx_in  = '0;
               pend_in = 1'b0;
            end
         end
         ST_SEND: begin
            if (fin_ff || (cnt_ff >= WINDOW_CNT)) begin
               stage_in = '{kind: EV_REFUSED, seq: ws_ff, slot: 4'd0};
            end else begin
               stage_in = '{kind: EV_SENT, seq: u_res, slot: 4'(cnt_ff)};
               cd_we    = 1'b1;
               cd_waddr = cnt_ff[SLOT_W-1:0];
               acked_in[cnt_ff[SLOT_W-1:0]] = 1'b0;
               cnt_in   = cnt_ff + CNT_W'(1);
               fin_in   = fin_ff || fpk_ff;
            end
         end
         ST_ACK_RED: begin
            ack_in = u_res;
         end
         ST_ACK_OFF: begin
            if (!off_inside) begin
               stage_in = '{kind: EV_IGNORED, seq: ws_ff, slot: 4'd0};
            end else begin
               acked_in[u_res[SLOT_W-1:0]] = 1'b1;
               stage_in = '{kind: EV_ACKED, seq: ws_ff, slot: 4'(u_res)};
            end
         end
         ST_RUN: begin
            if (scan_live && acked_ff[rd_slot]) begin
               idx_in = idx_ff + CNT_W'(1);
            end else begin
               run_in = idx_ff;
               idx_in = '0;
            end
         end
         ST_SHIFT: begin
            // move the slot run places ahead down to this one
            if (rd_idx < {1'b0, cnt_ff}) begin
               acked_in[idx_ff[SLOT_W-1:0]] = acked_ff[rd_slot];
               cd_we    = 1'b1;
               cd_wdata = cd_rd;
            end else begin
               acked_in[idx_ff[SLOT_W-1:0]] = 1'b0;
            end
            idx_in = idx_ff + CNT_W'(1);
         end
         ST_SLIDE: begin
            cnt_in   = cnt_ff - run_ff;
            ws_in    = u_res;
            stage_in = '{kind: EV_ACKED, seq: u_res, slot: 4'd0};
         end
         ST_SCAN: begin
            if (scan_live) begin
               if (!slot_open) begin
                  idx_in = idx_ff + CNT_W'(1);
               end else if (!expire) begin
                  cd_we    = 1'b1;
                  cd_wdata = cd_dec;
                  idx_in   = idx_ff + CNT_W'(1);
               end else if (!pend_ff || out_free) begin
                  // staged event is not the last, a later one was found
                  out_load = pend_ff;
                  out_last = 1'b0;
                  stage_in = '{kind: EV_RESENT, seq: u_res, slot: 4'(idx_ff)};
                  pend_in  = 1'b1;
                  cd_we    = 1'b1;
                  idx_in   = idx_ff + CNT_W'(1);
               end
            end else if (pend_ff && out_free) begin
               out_load = 1'b1;
               pend_in  = 1'b0;
            end
         end
         ST_EMIT: begin
            out_load = out_free;
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
   end

   always_comb begin
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      out_flight_in = out_flight_ff;
      out_done_in   = out_done_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (out_load) begin
         out_in        = stage_ff;
         out_last_in   = out_last;
         out_flight_in = 4'(cnt_ff);
         out_done_in   = fin_ff && (cnt_ff == '0);
         rsp_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ws_ff        <= seq_type'(1);
         cnt_ff       <= '0;
         fin_ff       <= 1'b0;
         acked_ff     <= '0;
         to_ff        <= TIMEOUT_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ws_ff        <= ws_in;
         cnt_ff       <= cnt_in;
         fin_ff       <= fin_in;
         acked_ff     <= acked_in;
         to_ff        <= to_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      run_ff        <= run_in;
      ack_ff        <= ack_in;
      fpk_ff        <= fpk_in;
      stage_ff      <= stage_in;
      out_ff        <= out_in;
      out_last_ff   <= out_last_in;
      out_flight_ff <= out_flight_in;
      out_done_ff   <= out_done_in;
   end

   always_ff @(posedge clock) begin
      if (cd_we) begin
         cd_ff[cd_waddr] <= cd_wdata;
      end
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_kind    = out_ff.kind;
   assign rsp_seq_number    = out_ff.seq;
   assign rsp_slot_index    = out_ff.slot;
   assign rsp_in_flight     = out_flight_ff;
   assign rsp_transfer_done = out_done_ff;
   assign rsp_last_of_run   = out_last_ff;

   `SRSW_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_ff <= WINDOW_CNT, "window count above depth")
   `SRSW_ASSERT_SAME(a_pend_scan, pend_ff, state_ff == ST_SCAN, "staged resend outside scan")
   `SRSW_ASSERT_SAME(a_scan_idx, state_ff == ST_SCAN, idx_ff <= cnt_ff, "scan index past window")
   `SRSW_ASSERT_SAME(a_slide_run, state_ff == ST_SLIDE,
                     (run_ff != '0) && (run_ff <= cnt_ff), "slide run out of range")
   `SRSW_ASSERT_NEXT(a_slide_cnt, state_ff == ST_SLIDE,
                     cnt_ff == $past(cnt_ff) - $past(run_ff), "slide count not reduced")

endmodule

>>> dv/tb_selective_repeat_send_window_unit.sv
`timescale 1ns / 100ps

module tb_selective_repeat_send_window_unit;
   import srsw_pkg::*;

   localparam int SLOTS = WINDOW_DEFAULT;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_SHOWN = 10;
   localparam int PHASE_ITEMS = 38;

   typedef struct packed {
      event_kind_type kind;
      seq_type        seq;
      logic [3:0]     slot;
      logic [3:0]     in_flight;
      logic           done;
      logic           last;
   } window_event_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_command;
   logic [14:0] req_ack_number;
   logic        req_final_packet;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_event_kind;
   logic [14:0] rsp_seq_number;
   logic [3:0]  rsp_slot_index;
   logic [3:0]  rsp_in_flight;
   logic        rsp_transfer_done;
   logic        rsp_last_of_run;
   logic        csr_write_enable;
   logic [0:0]  csr_index;
   logic [19:0] csr_write_data;

   selective_repeat_send_window_unit DUT (.*);

   // shadow copy of the sender window
   logic [14:0]      cfg_base;
   logic [19:0]      cfg_timeout;
   int unsigned      win_start;
   int unsigned      in_flight_cnt;
   bit               all_sent;
   bit               slot_acked_q[SLOTS];
   int unsigned      slot_timer[SLOTS];
   window_event_type pending_events[$];

   bit          idle_enable;
   int          stall_left;
   int unsigned mismatch_count;
   int unsigned requests_sent;
   int unsigned responses_seen;
   int unsigned restarts;
   int unsigned kind_count[5];

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int unsigned live_timeout();
      return (cfg_timeout == 20'd0) ? 1 : cfg_timeout;
   endfunction

   function automatic void restart_window();
      win_start = ((cfg_base % SEQ_SPACE) + 1) % SEQ_SPACE;
      in_flight_cnt = 0;
      all_sent = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_acked_q[i] = 1'b0;
         slot_timer[i] = 0;
      end
   endfunction

   function automatic window_event_type make_event(event_kind_type kind, int unsigned seq,
                                                   int unsigned slot);
      window_event_type ev;
      ev.kind = kind;
      ev.seq = seq_type'(seq);
      ev.slot = slot[3:0];
      ev.in_flight = in_flight_cnt[3:0];
      ev.done = all_sent && in_flight_cnt == 0;
      ev.last = 1'b0;
      return ev;
   endfunction

   function automatic logic [14:0] ack_for_slot(int unsigned off);
      return 15'((win_start + off + 1) % SEQ_SPACE);
   endfunction

   // works out the events one request causes and queues them in order
   function automatic void predict_window_events(logic [1:0] cmd, logic [14:0] ack, logic fin);
      window_event_type batch[$];
      window_event_type ev;
      int unsigned      slot;
      int unsigned      off;
      int unsigned      run;
      int unsigned      i;
      if (cmd == CMD_SEND) begin
         if (all_sent || in_flight_cnt >= SLOTS) begin
            batch.push_back(make_event(EV_REFUSED, win_start, 0));
         end else begin
            slot = in_flight_cnt;
            slot_acked_q[slot] = 1'b0;
            slot_timer[slot] = live_timeout();
            in_flight_cnt++;
            if (fin) all_sent = 1'b1;
            batch.push_back(make_event(EV_SENT, (win_start + slot) % SEQ_SPACE, slot));
         end
      end else if (cmd == CMD_ACK) begin
         off = ((ack % SEQ_SPACE) + SEQ_SPACE - win_start + SEQ_SPACE - 1) % SEQ_SPACE;
         if (off >= in_flight_cnt) begin
            batch.push_back(make_event(EV_IGNORED, win_start, 0));
         end else begin
            slot_acked_q[off] = 1'b1;
            if (off == 0) begin
               // slide past the run of acknowledged slots at the front
               run = 0;
               while (run < in_flight_cnt && slot_acked_q[run]) run++;
               for (i = 0; i + run < in_flight_cnt; i++) begin
                  slot_acked_q[i] = slot_acked_q[i + run];
                  slot_timer[i] = slot_timer[i + run];
               end
               for (i = in_flight_cnt - run; i < in_flight_cnt; i++) slot_acked_q[i] = 1'b0;
               in_flight_cnt -= run;
               win_start = (win_start + run) % SEQ_SPACE;
            end
            batch.push_back(make_event(EV_ACKED, win_start, off));
         end
      end else if (cmd == CMD_TICK) begin
         for (i = 0; i < in_flight_cnt && i < SLOTS; i++) begin
            if (!slot_acked_q[i]) begin
               if (slot_timer[i] > 0) slot_timer[i]--;
               if (slot_timer[i] == 0) begin
                  slot_timer[i] = live_timeout();
                  batch.push_back(make_event(EV_RESENT, (win_start + i) % SEQ_SPACE, i));
               end
            end
         end
      end
      for (i = 0; i < batch.size(); i++) begin
         ev = batch[i];
         ev.last = (i == batch.size() - 1);
         pending_events.push_back(ev);
      end
   endfunction

   function automatic void note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN)
         $display("[%0t] mismatch on response %0d: %s", $realtime, responses_seen, msg);
   endfunction

   always @(posedge clock) begin : check_responses
      window_event_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (rsp_event_kind <= EV_REFUSED) kind_count[rsp_event_kind]++;
         if (pending_events.size() == 0) begin
            note_mismatch($sformatf("kind %0d seq %0d slot %0d arrived with nothing pending",
                                    rsp_event_kind, rsp_seq_number, rsp_slot_index));
         end else begin
            want = pending_events.pop_front();
            if (rsp_event_kind !== want.kind)
               note_mismatch($sformatf("event_kind expected %0d got %0d",
                                       want.kind, rsp_event_kind));
            if (rsp_seq_number !== want.seq)
               note_mismatch($sformatf("seq_number expected %0d got %0d",
                                       want.seq, rsp_seq_number));
            if (rsp_slot_index !== want.slot)
               note_mismatch($sformatf("slot_index expected %0d got %0d",
                                       want.slot, rsp_slot_index));
            if (rsp_in_flight !== want.in_flight)
               note_mismatch($sformatf("in_flight expected %0d got %0d",
                                       want.in_flight, rsp_in_flight));
            if (rsp_transfer_done !== want.done)
               note_mismatch($sformatf("transfer_done expected %0d got %0d",
                                       want.done, rsp_transfer_done));
            if (rsp_last_of_run !== want.last)
               note_mismatch($sformatf("last_of_run expected %0d got %0d",
                                       want.last, rsp_last_of_run));
         end
      end
   end

   // receiver back-pressure in short bursts
   always @(negedge clock) begin
      if (stall_left == 0 && idle_enable && $urandom_range(0, 5) == 0)
         stall_left = $urandom_range(1, 4);
      if (stall_left != 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   task automatic send_request(logic [1:0] cmd, logic [14:0] ack, logic fin);
      if (idle_enable && $urandom_range(0, 2) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_command = cmd;
      req_ack_number = ack;
      req_final_packet = fin;
      do begin
         @(posedge clock);
      end while (!req_ready);
      predict_window_events(cmd, ack, fin);
      requests_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // a quiet tick may still be scanning after the last response
   task automatic wait_window_quiet();
      while (pending_events.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(csr_reg_type idx, logic [19:0] data);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (idx == CSR_BASE_SEQ) begin
         cfg_base = data[14:0];
         restart_window();
         restarts++;
      end else begin
         cfg_timeout = data;
      end
   endtask

   task automatic test_empty_window();
      send_request(CMD_ACK, 15'd1, 1'b0);
      send_request(CMD_TICK, 15'h7FFF, 1'b1);
      send_request(CMD_UNUSED, 15'h7FFF, 1'b1);
   endtask

   task automatic test_full_window_wrap();
      wait_window_quiet();
      // window start lands on the top sequence number and wraps to zero
      write_register(CSR_BASE_SEQ, 20'd25599);
      write_register(CSR_TIMEOUT, 20'd1);
      repeat (SLOTS) send_request(CMD_SEND, 15'd0, 1'b0);
      send_request(CMD_SEND, 15'd0, 1'b0);
      send_request(CMD_ACK, ack_for_slot(3), 1'b0);
      send_request(CMD_ACK, ack_for_slot(3), 1'b0);
      send_request(CMD_ACK, 15'h7FFF, 1'b0);
      send_request(CMD_TICK, 15'd0, 1'b0);
      send_request(CMD_ACK, ack_for_slot(0), 1'b0);
      send_request(CMD_ACK, ack_for_slot(1), 1'b0);
      send_request(CMD_ACK, ack_for_slot(0), 1'b0);
   endtask

   task automatic test_last_packet_zero_timeout();
      wait_window_quiet();
      write_register(CSR_BASE_SEQ, 20'd32767);
      write_register(CSR_TIMEOUT, 20'd0);
      send_request(CMD_SEND, 15'd0, 1'b0);
      send_request(CMD_SEND, 15'd0, 1'b1);
      send_request(CMD_SEND, 15'd0, 1'b0);
      send_request(CMD_TICK, 15'd0, 1'b0);
      send_request(CMD_ACK, ack_for_slot(1), 1'b0);
      send_request(CMD_ACK, ack_for_slot(0), 1'b0);
   endtask

   task automatic test_random_traffic(logic [19:0] base_word, logic [19:0] timeout_word,
                                      int unsigned count);
      int unsigned done_items;
      int unsigned pick;
      int unsigned off;
      logic [14:0] ack;
      wait_window_quiet();
      write_register(CSR_TIMEOUT, timeout_word);
      write_register(CSR_BASE_SEQ, base_word);
      done_items = 0;
      while (done_items < count) begin
         if (all_sent && in_flight_cnt == 0) begin
            // transfer complete, open a fresh connection
            wait_window_quiet();
            write_register(CSR_BASE_SEQ, 20'($urandom_range(0, 20'hFFFFF)));
         end
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            send_request(CMD_SEND, 15'($urandom_range(0, 32767)), $urandom_range(0, 19) == 0);
         end else if (pick < 70) begin
            off = $urandom_range(0, 9);
            if (off == 0 || in_flight_cnt == 0) begin
               ack = 15'($urandom_range(0, 32767));
            end else if (off == 1) begin
               ack = ack_for_slot(in_flight_cnt);
            end else begin
               off = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, in_flight_cnt - 1);
               ack = ack_for_slot(off);
            end
            send_request(CMD_ACK, ack, 1'($urandom_range(0, 1)));
         end else if (pick < 95) begin
            send_request(CMD_TICK, 15'($urandom_range(0, 32767)), 1'($urandom_range(0, 1)));
         end else begin
            send_request(CMD_UNUSED, 15'($urandom_range(0, 32767)),
                         1'($urandom_range(0, 1)));
         end
         if (pick < 95) done_items++;
      end
   endtask

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int unsigned waited;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_SEND;
      req_ack_number = 15'd0;
      req_final_packet = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_BASE_SEQ;
      csr_write_data = 20'd0;
      idle_enable = 1'b1;
      stall_left = 0;
      mismatch_count = 0;
      requests_sent = 0;
      responses_seen = 0;
      restarts = 0;
      for (int k = 0; k < 5; k++) kind_count[k] = 0;
      cfg_base = 15'd0;
      cfg_timeout = TIMEOUT_RESET;
      restart_window();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_window();
      test_full_window_wrap();
      test_last_packet_zero_timeout();
      test_random_traffic(20'($urandom_range(0, 25600)), 20'($urandom_range(1, 6)),
                          PHASE_ITEMS);
      test_random_traffic(20'd25600, 20'd1000000, PHASE_ITEMS);
      test_random_traffic(20'($urandom_range(0, 20'hFFFFF)), 20'd0, PHASE_ITEMS);
      test_random_traffic(20'($urandom_range(0, 20'hFFFFF)), 20'hFFFFF, PHASE_ITEMS);
      idle_enable = 1'b0;
      test_random_traffic(20'($urandom_range(0, 25600)), 20'($urandom_range(2, 5)),
                          PHASE_ITEMS);

      waited = 0;
      while (pending_events.size() != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      if (pending_events.size() != 0)
         note_mismatch($sformatf("%0d responses never arrived", pending_events.size()));
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("ran %0d requests over %0d connections, %0d responses checked",
               requests_sent, restarts, responses_seen);
      $display("sent %0d resent %0d acked %0d ignored %0d refused %0d, mismatches %0d",
               kind_count[EV_SENT], kind_count[EV_RESENT], kind_count[EV_ACKED],
               kind_count[EV_IGNORED], kind_count[EV_REFUSED], mismatch_count);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> selective_repeat_send_window_unit.f
+incdir+src
src/srsw_pkg.sv
src/srsw_mod_unit.sv
src/selective_repeat_send_window_unit.sv
dv/tb_selective_repeat_send_window_unit.sv
